// ----- rtl/fbcm_pkg.sv -----
// shared types, field widths and operation codes of the block chain manager
package fbcm_pkg;

	localparam int OP_W  = 3;
	localparam int BLK_W = 12;
	localparam int CNT_W = 13;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// operation codes
	localparam op_t OP_FORMAT = 3'd0;
	localparam op_t OP_ALLOC  = 3'd1;
	localparam op_t OP_APPEND = 3'd2;
	localparam op_t OP_FIND   = 3'd3;
	localparam op_t OP_FREE   = 3'd4;
	localparam op_t OP_NEXT   = 3'd5;
	localparam op_t OP_COUNT  = 3'd6;

	// status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_NO_FREE = 1'b1;

	// reset value of the first data block register
	localparam blk_t FDB_RESET = 12'd16;

	// one result item
	typedef struct packed {
		logic status;
		blk_t block_out;
		logic is_last;
		cnt_t block_count;
	} res_t;

endpackage

// ----- rtl/fbcm_req_if.sv -----
// request channel: operation code and block number
interface fbcm_req_if;
	logic             valid;
	logic             ready;
	fbcm_pkg::op_t    op;
	fbcm_pkg::blk_t   block_in;

	modport source (output valid, output op, output block_in, input ready);
	modport sink   (input valid, input op, input block_in, output ready);
endinterface

// ----- rtl/fbcm_rsp_if.sv -----
// response channel: status, block, end-of-chain flag and block count
interface fbcm_rsp_if;
	logic             valid;
	logic             ready;
	logic             status;
	fbcm_pkg::blk_t   block_out;
	logic             is_last;
	fbcm_pkg::cnt_t   block_count;

	modport source (output valid, output status, output block_out, output is_last,
		output block_count, input ready);
	modport sink   (input valid, input status, input block_out, input is_last,
		input block_count, output ready);
endinterface

// ----- rtl/fbcm_link_mem.sv -----
// link table memory: one write port, one read port, registered read data
module fbcm_link_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/fat_block_chain_manager.sv -----
// top level: block link table with free list, sequencer around one link memory
// out-of-range or empty-list requests are answered from the idle state; find last, count and free
//   read one link per visited block, and format writes every table entry
// throughput: one request at a time; each link visited costs one read of the link memory
// reset: first data block and free head become 16, the link table is undefined until a
//   format request writes it; no clearing pass runs after reset
module fat_block_chain_manager #(
	parameter int NUM_BLOCKS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  fbcm_pkg::blk_t cfg_wdata,
	fbcm_req_if.sink       req,
	fbcm_rsp_if.source     rsp
);
	import fbcm_pkg::*;

	localparam int LW = $clog2(NUM_BLOCKS);
	localparam int FW = $clog2(NUM_BLOCKS + 1);
	localparam int CW = ((LW > BLK_W) ? LW : BLK_W) + 2;
	localparam logic [CW-1:0] NUM_C  = CW'(NUM_BLOCKS);
	localparam logic [LW-1:0] LAST_I = LW'(NUM_BLOCKS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_NEXT   = 3'd4;
	localparam logic [2:0] S_FMT    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]    state_q, state_d;
	blk_t          fdb_q;
	logic [FW-1:0] fh_q, fh_d;
	op_t           op_q;
	blk_t          blk_q;
	logic [LW-1:0] cur_q, cur_d;
	logic [FW-1:0] n_q, n_d;
	logic [LW-1:0] idx_q, idx_d;

	logic          mem_we, mem_re;
	logic [LW-1:0] mem_waddr, mem_wdata, mem_raddr, rd_data;

	res_t          res, out_q, r_q;
	logic          res_load, out_valid_q, out_free;

	blk_t          fdb_eff;
	logic          fdb_ok, fh_ok, blk_ok;
	logic          accept;

	fbcm_link_mem #(
		.DEPTH (NUM_BLOCKS),
		.AW    (LW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// range checks
	assign fdb_eff  = (fdb_q == '0) ? BLK_W'(1) : fdb_q;
	assign fdb_ok   = CW'(fdb_eff) < NUM_C;
	assign fh_ok    = (fh_q != '0) && (CW'(fh_q) < NUM_C);
	assign blk_ok   = CW'(req.block_in) < NUM_C;

	// handshake
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// sequencer
	always_comb begin
		state_d   = state_q;
		fh_d      = fh_q;
		cur_d     = cur_q;
		n_d       = n_q;
		idx_d     = idx_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = LW'(req.block_in);
		res       = '0;
		res_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.op)
						OP_FORMAT: begin
							idx_d   = '0;
							state_d = S_FMT;
						end
						OP_ALLOC, OP_APPEND: begin
							if (req.op == OP_APPEND && !blk_ok) begin
								res_load = 1'b1;
							end else if (fh_ok) begin
								mem_re    = 1'b1;
								mem_raddr = LW'(fh_q);
								state_d   = S_ALLOC;
							end else begin
								res.status = ST_NO_FREE;
								res_load   = 1'b1;
							end
						end
						OP_FIND, OP_COUNT, OP_FREE: begin
							if (blk_ok && !(req.op == OP_FREE && req.block_in == '0)) begin
								mem_re  = 1'b1;
								cur_d   = LW'(req.block_in);
								n_d     = FW'(1);
								state_d = S_WALK;
							end else begin
								res_load = 1'b1;
							end
						end
						OP_NEXT: begin
							if (blk_ok) begin
								mem_re  = 1'b1;
								state_d = S_NEXT;
							end else begin
								res.is_last = 1'b1;
								res_load    = 1'b1;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				// unlink the taken head and advance the free list
				mem_we    = 1'b1;
				mem_waddr = LW'(fh_q);
				mem_wdata = '0;
				fh_d      = FW'(rd_data);
				cur_d     = LW'(fh_q);
				if (op_q == OP_APPEND) begin
					state_d = S_APPEND;
				end else begin
					res.block_out = BLK_W'(fh_q);
					res_load      = 1'b1;
				end
			end
			S_APPEND: begin
				mem_we        = 1'b1;
				mem_waddr     = LW'(blk_q);
				mem_wdata     = cur_q;
				res.block_out = BLK_W'(cur_q);
				res_load      = 1'b1;
			end
			S_WALK: begin
				if ((CW'(n_q) < NUM_C) && (rd_data != '0)) begin
					// follow the link
					cur_d     = rd_data;
					n_d       = FW'(n_q + 1'b1);
					mem_re    = 1'b1;
					mem_raddr = rd_data;
				end else begin
					res_load = 1'b1;
					case (op_q)
						OP_FIND: begin
							res.block_out = BLK_W'(cur_q);
							res.is_last   = (rd_data == '0);
						end
						OP_COUNT: begin
							res.block_count = CNT_W'(n_q);
						end
						OP_FREE: begin
							mem_we    = 1'b1;
							mem_waddr = cur_q;
							mem_wdata = LW'(fh_q);
							fh_d      = FW'(blk_q);
						end
						default: begin
						end
					endcase
				end
			end
			S_NEXT: begin
				res.block_out = BLK_W'(rd_data);
				res.is_last   = (rd_data == '0);
				res_load      = 1'b1;
			end
			S_FMT: begin
				// one entry per cycle: reserved blocks zero, data blocks chained
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				if ((CW'(idx_q) >= CW'(fdb_eff)) && (CW'(idx_q) + 1'b1 < NUM_C)) begin
					mem_wdata = LW'(CW'(idx_q) + 1'b1);
				end
				idx_d = LW'(CW'(idx_q) + 1'b1);
				if (idx_q == LAST_I) begin
					fh_d     = fdb_ok ? FW'(fdb_eff) : '0;
					res_load = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (res_load) begin
			state_d = out_free ? S_IDLE : S_DONE;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fdb_q       <= FDB_RESET;
			fh_q        <= FW'(FDB_RESET);
			n_q         <= FW'(1);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fh_q    <= fh_d;
			n_q     <= n_d;
			idx_q   <= idx_d;
			if (cfg_we) begin
				fdb_q <= cfg_wdata;
			end
			if ((res_load && out_free) || (state_q == S_DONE && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (accept) begin
			op_q  <= req.op;
			blk_q <= req.block_in;
		end
		if (res_load) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				r_q <= res;
			end
		end else if (state_q == S_DONE && out_free) begin
			out_q <= r_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.block_out   = out_q.block_out;
	assign rsp.is_last     = out_q.is_last;
	assign rsp.block_count = out_q.block_count;

	// no read and write of the same entry in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("link memory read and write collide");

	// walk length stays within the table size
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((n_q != '0) && (CW'(n_q) <= NUM_C)))
		else $error("chain walk count out of bounds");

	// format leaves the free head empty or inside the table
	a_fmt_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FMT && idx_q == LAST_I) |=> ((fh_q == '0) || (CW'(fh_q) < NUM_C)))
		else $error("free head out of range after format");

	// a result waiting in the holding state is not lost
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> out_valid_q)
		else $error("holding a result with an empty output register");

endmodule

// ----- sim/fbcm_tb_pkg.sv -----
`timescale 1ns / 100ps
// link table scoreboard: predicts each response and checks what the block returns
package fbcm_tb_pkg;
	import fbcm_pkg::*;

	localparam int  TABLE_SIZE = 4096;
	localparam op_t OP_UNUSED  = 3'd7;
	localparam int  REPORT_MAX = 200;

	class link_table_scoreboard;
		blk_t links [TABLE_SIZE];
		blk_t free_head;
		blk_t first_data;
		res_t pending_results [$];
		int   mismatches;

		function new();
			first_data = FDB_RESET;
			free_head  = FDB_RESET;
			mismatches = 0;
			foreach (links[i]) links[i] = '0;
		endfunction

		// follow links from start, giving up after a full table of blocks
		function blk_t walk_chain(blk_t start, output int steps);
			blk_t cur;
			cur   = start;
			steps = 1;
			while (steps < TABLE_SIZE && links[cur] != '0) begin
				cur = links[cur];
				steps++;
			end
			return cur;
		endfunction

		// pop the free list head, zero when the list is empty
		function blk_t take_free();
			blk_t b;
			b = free_head;
			if (b == '0 || int'(b) >= TABLE_SIZE) return '0;
			free_head = links[b];
			links[b]  = '0;
			return b;
		endfunction

		// reserved blocks end chains, data blocks form one free chain
		function void format_table();
			int base;
			base = (first_data == '0) ? 1 : int'(first_data);
			for (int i = 0; i < TABLE_SIZE; i++)
				links[i] = (i >= base && i + 1 < TABLE_SIZE) ? blk_t'(i + 1) : blk_t'(0);
			free_head = (base < TABLE_SIZE) ? blk_t'(base) : blk_t'(0);
		endfunction

		// apply one accepted request and queue the response it must give
		function res_t note_request(op_t op, blk_t blk);
			res_t r;
			blk_t tail;
			int   steps;
			bit   blk_ok;
			r      = '0;
			blk_ok = int'(blk) < TABLE_SIZE;
			case (op)
				OP_FORMAT: format_table();
				OP_ALLOC: begin
					r.block_out = take_free();
					r.status    = (r.block_out == '0) ? ST_NO_FREE : ST_OK;
				end
				OP_APPEND: if (blk_ok) begin
					r.block_out = take_free();
					if (r.block_out == '0) r.status = ST_NO_FREE;
					else links[blk] = r.block_out;
				end
				OP_FIND: if (blk_ok) begin
					r.block_out = walk_chain(blk, steps);
					r.is_last   = (links[r.block_out] == '0);
				end
				OP_FREE: if (blk_ok && blk != '0) begin
					tail        = walk_chain(blk, steps);
					links[tail] = free_head;
					free_head   = blk;
				end
				OP_NEXT: begin
					if (blk_ok) r.block_out = links[blk];
					r.is_last = (r.block_out == '0);
				end
				OP_COUNT: if (blk_ok) begin
					void'(walk_chain(blk, steps));
					r.block_count = cnt_t'(steps);
				end
				default: ;
			endcase
			pending_results.push_back(r);
			return r;
		endfunction

		function void field_error(string field, int want, int got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		// compare one response with the oldest prediction
		function void check_response(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response with no request pending, expected none, actual block_out %0d",
						$time, got.block_out);
				return;
			end
			want = pending_results.pop_front();
			if (got.status != want.status)
				field_error("status", want.status, got.status);
			if (got.block_out != want.block_out)
				field_error("block_out", want.block_out, got.block_out);
			if (got.is_last != want.is_last)
				field_error("is_last", want.is_last, got.is_last);
			if (got.block_count != want.block_count)
				field_error("block_count", want.block_count, got.block_count);
		endfunction
	endclass

endpackage

// ----- sim/tb_fat_block_chain_manager.sv -----
`timescale 1ns / 100ps
// testbench top: drives requests into the block chain manager and checks every response
module tb_fat_block_chain_manager;
	import fbcm_pkg::*;
	import fbcm_tb_pkg::*;

	localparam int LIMIT_CYCLES     = 4000000;
	localparam int HOLD_CYCLES      = 400;
	localparam int RANDOM_PER_PHASE = 460;
	localparam int MAX_CHAIN_LEN    = 24;
	localparam int SETTLE_CYCLES    = 16;

	logic clk;
	logic arst_n;
	logic cfg_we;
	blk_t cfg_wdata;

	fbcm_req_if req_ch ();
	fbcm_rsp_if rsp_ch ();

	fat_block_chain_manager i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	link_table_scoreboard chain_sb;

	int   send_idle_pct = 14;
	int   recv_idle_pct = 69;
	int   cycle_count   = 0;
	bit   hold_request  = 1'b0;
	int   hold_left     = 0;

	// chains this side has allocated and still owns
	blk_t chain_head [$];
	blk_t chain_tail [$];
	int   chain_len  [$];

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// response ready: random stalls, or one long hold when asked
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			chain_sb.check_response({rsp_ch.status, rsp_ch.block_out, rsp_ch.is_last,
				rsp_ch.block_count});
	end

	// offer one request, note it once it is taken
	task automatic send_request(op_t op, blk_t blk, output res_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.block_in <= blk;
		do
			@(posedge clk);
		while (!req_ch.ready);
		want = chain_sb.note_request(op, blk);
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (chain_sb.pending_results.size() != 0);
	endtask

	task automatic write_first_data(blk_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		chain_sb.first_data = value;
		cfg_we <= 1'b0;
	endtask

	function automatic void forget_chains();
		chain_head.delete();
		chain_tail.delete();
		chain_len.delete();
	endfunction

	function automatic void drop_chain(int k);
		chain_head.delete(k);
		chain_tail.delete(k);
		chain_len.delete(k);
	endfunction

	// extremes, every operation and the corner cases
	task automatic run_directed();
		res_t want;
		// reset setting: free list runs from 16 to the top
		send_request(OP_FORMAT, 12'd0, want);
		send_request(OP_COUNT, 12'd16, want);
		send_request(OP_NEXT, 12'd0, want);
		send_request(OP_NEXT, 12'd15, want);
		send_request(OP_NEXT, 12'd16, want);
		send_request(OP_ALLOC, 12'hfff, want);
		send_request(OP_ALLOC, 12'd0, want);
		send_request(OP_APPEND, 12'd16, want);
		send_request(OP_FIND, 12'd16, want);
		send_request(OP_COUNT, 12'd16, want);
		send_request(OP_COUNT, 12'd4095, want);
		// block zero is never put on the free list
		send_request(OP_FREE, 12'd0, want);
		send_request(OP_FREE, 12'd16, want);
		send_request(OP_UNUSED, 12'd4095, want);
		send_request(OP_NEXT, 12'd4095, want);
		drain();

		// only the top block is data: one allocation, then the list is empty
		write_first_data(12'd4095);
		send_request(OP_FORMAT, 12'd4095, want);
		send_request(OP_ALLOC, 12'd0, want);
		send_request(OP_ALLOC, 12'd0, want);
		send_request(OP_APPEND, 12'd4095, want);
		drain();

		// zero reserved blocks counts as one; freeing a free block loops the list
		write_first_data(12'd0);
		send_request(OP_FORMAT, 12'd0, want);
		send_request(OP_FREE, 12'd2, want);
		send_request(OP_COUNT, 12'd2, want);
		send_request(OP_FIND, 12'd2, want);
		send_request(OP_ALLOC, 12'd0, want);
	endtask

	// mostly well-formed chain work, with a little noise
	task automatic run_random(int count);
		res_t want;
		int   pick;
		int   k;
		blk_t noise;
		repeat (count) begin
			pick  = $urandom_range(999);
			noise = blk_t'($urandom_range(4095));
			k     = (chain_head.size() != 0) ? $urandom_range(chain_head.size() - 1) : 0;
			if (pick >= 860) begin
				// noise on arbitrary blocks
				if (pick < 950) begin
					send_request(OP_NEXT, noise, want);
				end else if (pick < 970) begin
					send_request(OP_UNUSED, noise, want);
				end else if (pick < 980) begin
					send_request($urandom_range(1) ? OP_FIND : OP_COUNT, noise, want);
				end else if (pick < 986) begin
					send_request(OP_FORMAT, noise, want);
					forget_chains();
				end else begin
					// may tear an owned chain apart, so ownership is dropped
					send_request(OP_FREE, ($urandom_range(3) == 0) ? blk_t'(0) : noise, want);
					forget_chains();
				end
			end else if (chain_head.size() == 0 || pick < 200) begin
				send_request(OP_ALLOC, noise, want);
				if (want.status == ST_OK) begin
					chain_head.push_back(want.block_out);
					chain_tail.push_back(want.block_out);
					chain_len.push_back(1);
				end
			end else if (pick < 420) begin
				if (chain_len[k] >= MAX_CHAIN_LEN) begin
					send_request(OP_FREE, chain_head[k], want);
					drop_chain(k);
				end else begin
					send_request(OP_APPEND, chain_tail[k], want);
					if (want.status == ST_OK) begin
						chain_tail[k] = want.block_out;
						chain_len[k]++;
					end
				end
			end else if (pick < 520) begin
				send_request(OP_FIND, chain_head[k], want);
			end else if (pick < 620) begin
				send_request(OP_COUNT, chain_head[k], want);
			end else if (pick < 700) begin
				send_request(OP_NEXT, $urandom_range(1) ? chain_head[k] : chain_tail[k], want);
			end else begin
				send_request(OP_FREE, chain_head[k], want);
				drop_chain(k);
			end
		end
	endtask

	// one setting of the register and of the idle rates
	task automatic run_phase(int send_pct, int recv_pct, blk_t first_data, bit long_hold);
		res_t want;
		drain();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_first_data(first_data);
		forget_chains();
		send_request(OP_FORMAT, blk_t'($urandom_range(4095)), want);
		hold_request = long_hold;
		run_random(RANDOM_PER_PHASE);
	endtask

	// main sequence
	initial begin
		chain_sb = new();
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_FORMAT;
		req_ch.block_in <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(14, 69, blk_t'($urandom_range(200, 1)), 1'b0);
		run_phase(69, 14, blk_t'($urandom_range(4060, 4000)), 1'b0);
		run_phase(0, 0, 12'd1, 1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chain_sb.mismatches == 0 && chain_sb.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fbcm_pkg.sv
rtl/fbcm_req_if.sv
rtl/fbcm_rsp_if.sv
rtl/fbcm_link_mem.sv
rtl/fat_block_chain_manager.sv
sim/fbcm_tb_pkg.sv
sim/tb_fat_block_chain_manager.sv
